>>> rtl/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
    localparam int FRAC_BITS_DEF = 8;
    localparam int DATA_W = 32;
    localparam int CMD_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
        CMD_GT = 4'd4, CMD_LT = 4'd5, CMD_GE = 4'd6, CMD_LE = 4'd7,
        CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
        CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_FROM_INT = 4'd14, CMD_TO_INT = 4'd15
    } t_cmd;

    // Item state carried down the divider chain.
    typedef struct packed {
        logic              vld;
        logic              neg;
        logic              dz;
        logic [2*DATA_W-1:0] rem;   // partial remainder
        logic [2*DATA_W-1:0] num;   // shifting dividend
        logic [DATA_W-1:0]   den;
        logic [2*DATA_W-1:0] quo;
        logic              is_div;
        logic [DATA_W-1:0]   res;   // result of non-divide commands
        logic              cmp;
    } t_cell;
endpackage
`default_nettype wire

>>> rtl/fpa_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_cell
    import fpa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_cell i_cell,
    output t_cell      o_cell
);
    t_cell r_cell;
    t_cell n_cell;
    logic [2*DATA_W:0] w_trial;
    logic [2*DATA_W-1:0] w_shift;

    // One restoring divide step: shift in a dividend bit, subtract if it fits.
    always_comb begin
        n_cell  = i_cell;
        w_shift = {i_cell.rem[2*DATA_W-2:0], i_cell.num[2*DATA_W-1]};
        w_trial = {1'b0, w_shift} - {{(DATA_W+1){1'b0}}, i_cell.den};
        n_cell.num = {i_cell.num[2*DATA_W-2:0], 1'b0};
        if (!w_trial[2*DATA_W]) begin
            n_cell.rem = w_trial[2*DATA_W-1:0];
            n_cell.quo = {i_cell.quo[2*DATA_W-2:0], 1'b1};
        end else begin
            n_cell.rem = w_shift;
            n_cell.quo = {i_cell.quo[2*DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= n_cell.vld;
        end
        if (i_en) begin
            r_cell.neg <= n_cell.neg;  r_cell.dz <= n_cell.dz;
            r_cell.rem <= n_cell.rem;  r_cell.num <= n_cell.num;
            r_cell.den <= n_cell.den;  r_cell.quo <= n_cell.quo;
            r_cell.is_div <= n_cell.is_div;
            r_cell.res <= n_cell.res;  r_cell.cmp <= n_cell.cmp;
        end
    end
    assign o_cell = r_cell;
endmodule
`default_nettype wire

>>> rtl/fpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_front
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic signed [DATA_W-1:0] i_a,
    input  wire logic signed [DATA_W-1:0] i_b,
    output t_cell                  o_cell
);
    t_cell r_cell;
    t_cell n_cell;
    logic [DATA_W-1:0] w_ma, w_mb;
    logic [2*DATA_W-1:0] w_prod, w_prod_sh, w_prod_sg;
    logic w_neg, w_lt, w_gt, w_eq;

    always_comb begin
        w_ma  = i_a[DATA_W-1] ? DATA_W'(-i_a) : DATA_W'(i_a);
        w_mb  = i_b[DATA_W-1] ? DATA_W'(-i_b) : DATA_W'(i_b);
        w_neg = i_a[DATA_W-1] ^ i_b[DATA_W-1];
        w_lt  = i_a < i_b;
        w_gt  = i_a > i_b;
        w_eq  = i_a == i_b;
        w_prod    = {{DATA_W{1'b0}}, w_ma} * {{DATA_W{1'b0}}, w_mb};
        w_prod_sh = w_prod >> FRAC_BITS;
        w_prod_sg = w_neg ? -w_prod_sh : w_prod_sh;
        n_cell        = '0;
        n_cell.vld    = i_vld;
        n_cell.neg    = w_neg;
        n_cell.den    = w_mb;
        n_cell.num    = {{DATA_W{1'b0}}, w_ma} << FRAC_BITS;
        n_cell.is_div = (i_cmd == CMD_DIV);
        n_cell.dz     = (i_cmd == CMD_DIV) && (i_b == '0);
        case (t_cmd'(i_cmd))
            CMD_ADD:      n_cell.res = i_a + i_b;
            CMD_SUB:      n_cell.res = i_a - i_b;
            CMD_MUL:      n_cell.res = w_prod_sg[DATA_W-1:0];
            CMD_GT:       n_cell.cmp = w_gt;
            CMD_LT:       n_cell.cmp = w_lt;
            CMD_GE:       n_cell.cmp = !w_lt;
            CMD_LE:       n_cell.cmp = !w_gt;
            CMD_EQ:       n_cell.cmp = w_eq;
            CMD_NE:       n_cell.cmp = !w_eq;
            CMD_MIN:      n_cell.res = w_lt ? i_a : i_b;
            CMD_MAX:      n_cell.res = w_gt ? i_a : i_b;
            CMD_INC:      n_cell.res = i_a + DATA_W'(1);
            CMD_DEC:      n_cell.res = i_a - DATA_W'(1);
            CMD_FROM_INT: n_cell.res = i_a << FRAC_BITS;
            CMD_TO_INT:   n_cell.res = i_a >>> FRAC_BITS;
            default:      n_cell.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= n_cell.vld;
        end
        if (i_en) begin
            r_cell.neg <= n_cell.neg;  r_cell.dz <= n_cell.dz;
            r_cell.rem <= n_cell.rem;  r_cell.num <= n_cell.num;
            r_cell.den <= n_cell.den;  r_cell.quo <= n_cell.quo;
            r_cell.is_div <= n_cell.is_div;
            r_cell.res <= n_cell.res;  r_cell.cmp <= n_cell.cmp;
        end
    end
    assign o_cell = r_cell;
endmodule
`default_nettype wire

>>> rtl/fixed_point_alu_q24_8.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: the front register, then the divider chain, then the output register.
// Throughput: one item per cycle unless the output stalls; the divider is a chain
// of 64 restoring-step cells and every command rides the same chain, so order is kept.
// The front stage holds one 32x32 multiplier. A stall on the output freezes the chain.
// Reset: synchronous, active low; clears all valid bits, the chain drains empty.
module fixed_point_alu_q24_8
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic signed [DATA_W-1:0] i_operand_a,
    input  wire logic signed [DATA_W-1:0] i_operand_b,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic                   o_compare_true,
    output logic                   o_divide_by_zero
);
    localparam int NCELL = 2 * DATA_W;

    t_cell w_chain [NCELL+1];
    logic  w_en;
    logic  r_valid;
    logic [DATA_W-1:0] r_res;
    logic  r_cmp, r_dz;
    logic [DATA_W-1:0] w_q;
    t_cell w_last;

    // Advance the whole chain unless the output register holds an untaken item.
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(i_valid), .i_cmd(i_command),
        .i_a(i_operand_a), .i_b(i_operand_b), .o_cell(w_chain[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        fpa_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_cell(w_chain[g]), .o_cell(w_chain[g+1])
        );
    end

    assign w_last = w_chain[NCELL];
    always_comb begin
        w_q = w_last.neg ? DATA_W'(-w_last.quo) : w_last.quo[DATA_W-1:0];
    end

    // Output register: resolve divide sign, zero divisor, else pass through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_last.vld;
        end
        if (w_en) begin
            r_cmp <= w_last.cmp;
            r_dz  <= w_last.dz;
            if (w_last.is_div) begin
                r_res <= w_last.dz ? '0 : w_q;
            end else begin
                r_res <= w_last.res;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_result_value   = r_res;
    assign o_compare_true   = r_cmp;
    assign o_divide_by_zero = r_dz;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value))
        else $error("result changed while stalled");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_result_value == '0 && !o_compare_true)
        else $error("divide by zero with nonzero result");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("chain advanced during stall");
endmodule
`default_nettype wire

>>> dv/fixed_point_alu_q24_8_test.sv
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_test;
    import fpa_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LATENCY = 2 + 2 * DATA_W;
    localparam int RANDOM_ITEMS = 1400;
    localparam longint CYCLE_LIMIT = 600000;

    // One input item: command and two raw operands.
    typedef struct {
        t_cmd               cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_op_t;

    // One result item as the block should return it.
    typedef struct {
        logic signed [31:0] value;
        logic               cmp;
        logic               dz;
    } alu_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [CMD_W-1:0] i_command = '0;
    logic signed [DATA_W-1:0] i_operand_a = '0;
    logic signed [DATA_W-1:0] i_operand_b = '0;
    logic i_ready = 1'b0;
    logic o_ready;
    logic o_valid;
    logic signed [DATA_W-1:0] o_result_value;
    logic o_compare_true;
    logic o_divide_by_zero;

    fixed_point_alu_q24_8 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_value  (o_result_value),
        .o_compare_true  (o_compare_true),
        .o_divide_by_zero(o_divide_by_zero)
    );

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       error_count = 0;
    int       checked_count = 0;
    int       dz_seen = 0;
    longint   cycle_count = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Compute the Q24.8 result of one item. Magnitudes go through 64-bit
    // unsigned math so that truncation is toward zero, then the sign is
    // applied and the low 32 bits kept.
    function automatic alu_res_t alu_predict(alu_op_t op);
        alu_res_t   r;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] mag;
        logic [63:0] signed_mag;
        logic        neg;
        r.value = '0;
        r.cmp = 1'b0;
        r.dz = 1'b0;
        mag_a = op.a[31] ? 64'(-64'(signed'(op.a))) : 64'(op.a);
        mag_b = op.b[31] ? 64'(-64'(signed'(op.b))) : 64'(op.b);
        mag_a = {32'd0, mag_a[31:0]} | (op.a == 32'sh80000000 ? 64'h8000_0000 : 64'd0);
        mag_b = {32'd0, mag_b[31:0]} | (op.b == 32'sh80000000 ? 64'h8000_0000 : 64'd0);
        neg = op.a[31] ^ op.b[31];
        case (op.cmd)
            CMD_ADD:      r.value = op.a + op.b;
            CMD_SUB:      r.value = op.a - op.b;
            CMD_MUL: begin
                mag = (mag_a * mag_b) >> FRAC;
                signed_mag = neg ? -mag : mag;
                r.value = signed_mag[31:0];
            end
            CMD_DIV: begin
                if (op.b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    mag = (mag_a << FRAC) / mag_b;
                    signed_mag = neg ? -mag : mag;
                    r.value = signed_mag[31:0];
                end
            end
            CMD_GT:       r.cmp = op.a > op.b;
            CMD_LT:       r.cmp = op.a < op.b;
            CMD_GE:       r.cmp = op.a >= op.b;
            CMD_LE:       r.cmp = op.a <= op.b;
            CMD_EQ:       r.cmp = op.a == op.b;
            CMD_NE:       r.cmp = op.a != op.b;
            CMD_MIN:      r.value = (op.a < op.b) ? op.a : op.b;
            CMD_MAX:      r.value = (op.a > op.b) ? op.a : op.b;
            CMD_INC:      r.value = op.a + 32'sd1;
            CMD_DEC:      r.value = op.a - 32'sd1;
            CMD_FROM_INT: r.value = op.a << FRAC;
            default:      r.value = op.a >>> FRAC;
        endcase
        return r;
    endfunction

    // Pick an operand: mostly small fixed-point values, some full range,
    // some corner words.
    function automatic logic signed [31:0] pick_operand();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sh7fffffff;
            1:       v = 32'sh80000000;
            2:       v = $signed($urandom_range(0, 4)) - 2;
            3, 4, 5: v = $urandom;
            6:       v = ($urandom & 32'h0000ffff) - 32'sh8000;
            default: v = ($urandom & 32'h00ffffff) - 32'sh800000;
        endcase
        return v;
    endfunction

    task automatic queue_op(t_cmd c, logic signed [31:0] a, logic signed [31:0] b);
        alu_op_t op;
        op.cmd = c;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    // Driver: present the head of the pending queue; hold it until accepted.
    always @(posedge i_clk) begin
        alu_op_t op;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_results.push_back(alu_predict(pending_ops.pop_front()));
            end
            if ((!i_valid || o_ready) && pending_ops.size() != 0
                    && !(i_valid && o_ready && pending_ops.size() == 0)
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                op = pending_ops[0];
                i_valid <= 1'b1;
                i_command <= op.cmd;
                i_operand_a <= op.a;
                i_operand_b <= op.b;
            end else if (!i_valid || o_ready) begin
                i_valid <= 1'b0;
            end
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        alu_res_t exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result value=%h cmp=%b dz=%b", $time,
                         o_result_value, o_compare_true, o_divide_by_zero);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                checked_count++;
                if (exp_r.dz) dz_seen++;
                if (o_result_value !== exp_r.value) begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             exp_r.value, o_result_value);
                    error_count++;
                end
                if (o_compare_true !== exp_r.cmp) begin
                    $display("%0t: compare_true expected %b actual %b", $time,
                             exp_r.cmp, o_compare_true);
                    error_count++;
                end
                if (o_divide_by_zero !== exp_r.dz) begin
                    $display("%0t: divide_by_zero expected %b actual %b", $time,
                             exp_r.dz, o_divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    // Abort on a hung handshake.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run timed out", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_cmd c;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every command once, then the edges of the arithmetic.
        for (int k = 0; k < 16; k++) begin
            c = t_cmd'(k);
            queue_op(c, 32'sh00000380, 32'shfffffe80);
        end
        queue_op(CMD_DIV, 32'sh00000500, 32'sh0);
        queue_op(CMD_DIV, 32'sh80000000, 32'shffffffff);
        queue_op(CMD_DIV, 32'sh7fffffff, 32'sh00000001);
        queue_op(CMD_MUL, 32'sh80000000, 32'sh80000000);
        queue_op(CMD_MUL, 32'shffffffff, 32'sh00000001);
        queue_op(CMD_ADD, 32'sh7fffffff, 32'sh00000001);
        queue_op(CMD_MIN, 32'sh00000100, 32'sh00000100);
        queue_op(CMD_TO_INT, 32'shffffff01, 32'sh0);
        queue_op(CMD_FROM_INT, 32'sh80ffffff, 32'shffffffff);

        // Random items over four pressure phases.
        for (int ph = 0; ph < 4; ph++) begin
            while (pending_ops.size() != 0) @(posedge i_clk);
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 23) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 59 : 23) : 0;
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                c = t_cmd'($urandom_range(0, 15));
                // Send a zero divisor now and then.
                if ($urandom_range(0, 9) == 0)
                    queue_op(CMD_DIV, pick_operand(), 32'sh0);
                else
                    queue_op(c, pick_operand(), pick_operand());
            end
        end

        while (pending_ops.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d results over all 16 commands, %0d with a zero divisor,",
                 checked_count, dz_seen);
        $display("under free-flowing, sender-idle, receiver-stall and mixed pressure.");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
